@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the countdown timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RCTA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is high.
`define RCTA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

@@ rtl/rcta_pkg.sv @@
// ----------------------------------------------------------------------------
// rcta_pkg
// Shared constants, codes, pattern tables and interface structs of the
// repeating countdown timer.
// ----------------------------------------------------------------------------
package rcta_pkg;

  localparam int PROGRESS_SPAN_DEF = 128;
  localparam int BEEP_WINDOW_DEF   = 1000;

  localparam int KIND_W    = 2;
  localparam int EL_W      = 29;
  localparam int DUR_S_W   = 19;
  localparam int REP_W     = 8;
  localparam int PROG_W    = 8;
  localparam int STEP_T_W  = 10;
  localparam int LSTEP_W   = 3;
  localparam int SSTEP_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int MS_PER_SEC = 1000;

  localparam logic [LSTEP_W-1:0] LONG_LAST = 3'd5;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DURATION = 1'b0,
    REG_REPEAT   = 1'b1
  } reg_idx_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic update;
    logic calc;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_last;
    logic out_busy;
  } sts_t;

  // Length in ticks of each step of the short beep pattern.
  function automatic logic [STEP_T_W-1:0] short_len(input logic [SSTEP_W-1:0] s);
    logic [STEP_T_W-1:0] len;
    unique case (s)
      2'd0:    len = 10'd120;
      2'd1:    len = 10'd80;
      2'd2:    len = 10'd120;
      default: len = 10'd500;
    endcase
    return len;
  endfunction

  // Length in ticks of each step of the long alarm pattern (six steps).
  function automatic logic [STEP_T_W-1:0] long_len(input logic [LSTEP_W-1:0] s);
    logic [STEP_T_W-1:0] len;
    unique case (s) inside
      3'd0, 3'd1, 3'd6, 3'd7: len = 10'd40;
      3'd2, 3'd3:             len = 10'd80;
      3'd4:                   len = 10'd160;
      default:                len = 10'd800;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/rcta_ctrl.sv @@
// ----------------------------------------------------------------------------
// rcta_ctrl
// Sequencer of the countdown timer: takes an item, steps the datapath
// through state update, result arithmetic and the progress divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcta_ctrl import rcta_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_UPD  = 6'b000100,
    S_CALC = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = S_LOAD;
        end
      end
      // The load state lets the registered millisecond duration settle after a register write.
      S_LOAD: state_next = S_UPD;
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  `RCTA_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == S_LOAD)
  `RCTA_ASSERT_NEXT(a_div_finishes, clk, rst, state == S_DIV && sts.div_last, state == S_DONE)
  `RCTA_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.out_load, !sts.out_busy)

endmodule

@@ rtl/rcta_datapath.sv @@
// ----------------------------------------------------------------------------
// rcta_datapath
// Timer state, beep pattern generators, configuration registers, the
// restoring progress divider and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcta_datapath import rcta_pkg::*; #(
  parameter int PROGRESS_SPAN  = PROGRESS_SPAN_DEF,
  parameter int BEEP_WINDOW_MS = BEEP_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [KIND_W-1:0]    kind,
  input  logic                 tap,
  input  logic                 hold,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_S_W-1:0]   cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [EL_W-1:0]      remaining_ms,
  output logic [PROG_W-1:0]    progress,
  output logic                 buzzer_on,
  output logic                 is_running,
  output logic                 alarm_active,
  output logic [REP_W-1:0]     runs_left
);

  localparam int QW   = $clog2(PROGRESS_SPAN + 1);
  localparam int NW   = EL_W + QW;
  localparam int CW   = (QW > 1) ? $clog2(QW) : 1;
  localparam int BW_W = $clog2(BEEP_WINDOW_MS + 2);
  localparam logic [BW_W-1:0] BW_VAL = BW_W'(BEEP_WINDOW_MS);

  // Configuration.
  logic [DUR_S_W-1:0] duration_seconds;
  logic [REP_W-1:0]   repeat_count;
  logic [EL_W-1:0]    dur_ms;

  // Latched item.
  kind_t kind_q;
  logic  tap_q;
  logic  hold_q;

  // Timer state.
  logic                running, running_next;
  logic [EL_W-1:0]     elapsed, elapsed_next;
  logic [REP_W-1:0]    repeats, repeats_next;
  logic                alarm_latched, alarm_next;
  logic [LSTEP_W-1:0]  long_step, long_step_next;
  logic [STEP_T_W-1:0] long_timer, long_timer_next;
  logic                short_beep_enabled, sbe_next;
  logic [SSTEP_W-1:0]  short_step, short_step_next;
  logic [STEP_T_W-1:0] short_timer, short_timer_next;
  logic [BW_W-1:0]     beep_timer, beep_timer_next;
  logic                buzzer_level, buzzer_next;
  logic                expire_final;

  logic [EL_W-1:0]     el_inc;
  logic [STEP_T_W-1:0] long_inc;
  logic [STEP_T_W-1:0] short_inc;

  // Result arithmetic.
  logic [EL_W-1:0] el_clamped;
  logic [EL_W-1:0] rem_q;
  logic            dur_zero_q;
  logic [NW-1:0]   num;
  logic [NW-1:0]   dsh;
  logic [QW-1:0]   quo;
  logic [CW-1:0]   cnt;
  logic            div_ge;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_seconds <= '0;
      repeat_count     <= REP_W'(1);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DURATION: duration_seconds <= cfg_data;
        REG_REPEAT:   repeat_count     <= cfg_data[REP_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dur_ms <= EL_W'(duration_seconds) * EL_W'(MS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= kind_t'(kind);
      tap_q  <= tap;
      hold_q <= hold;
    end
  end

  assign el_inc    = elapsed + 1'b1;
  assign long_inc  = long_timer + 1'b1;
  assign short_inc = short_timer + 1'b1;

  always_comb begin
    running_next     = running;
    elapsed_next     = elapsed;
    repeats_next     = repeats;
    alarm_next       = alarm_latched;
    long_step_next   = long_step;
    long_timer_next  = long_timer;
    sbe_next         = short_beep_enabled;
    short_step_next  = short_step;
    short_timer_next = short_timer;
    beep_timer_next  = beep_timer;
    buzzer_next      = buzzer_level;
    expire_final     = 1'b0;
    if (cmd.update) begin
      if (alarm_latched) begin
        // While the alarm is latched only ticks matter; hold silences it.
        if (kind_q == KIND_TICK) begin
          if (hold_q) begin
            alarm_next      = 1'b0;
            long_step_next  = '0;
            long_timer_next = '0;
            buzzer_next     = 1'b0;
          end else if (long_inc >= long_len(long_step)) begin
            long_timer_next = '0;
            long_step_next  = (long_step == LONG_LAST) ? '0 : long_step + 1'b1;
            buzzer_next     = ~long_step_next[0];
          end else begin
            long_timer_next = long_inc;
          end
        end
      end else begin
        case (kind_q)
          KIND_TICK: begin
            if (beep_timer <= BW_VAL) begin
              beep_timer_next = beep_timer + 1'b1;
            end
            running_next = running ^ tap_q;
            if (running_next) begin
              if (el_inc >= dur_ms) begin
                elapsed_next = '0;
                if (repeats > REP_W'(1)) begin
                  repeats_next    = repeats - 1'b1;
                  sbe_next        = 1'b1;
                  beep_timer_next = '0;
                end else begin
                  running_next    = 1'b0;
                  alarm_next      = 1'b1;
                  sbe_next        = 1'b0;
                  long_step_next  = '0;
                  long_timer_next = '0;
                  buzzer_next     = 1'b0;
                  expire_final    = 1'b1;
                end
              end else begin
                elapsed_next = el_inc;
              end
            end
            // The final expiry leaves the short pattern where it stood.
            if (!expire_final) begin
              if (!sbe_next) begin
                buzzer_next      = 1'b0;
                short_step_next  = '0;
                short_timer_next = '0;
              end else if (short_inc >= short_len(short_step)) begin
                short_timer_next = '0;
                short_step_next  = short_step + 1'b1;
                buzzer_next      = ~short_step_next[0];
              end else begin
                short_timer_next = short_inc;
              end
              if (beep_timer_next > BW_VAL) begin
                sbe_next = 1'b0;
              end
            end
          end
          KIND_START: begin
            elapsed_next = '0;
            repeats_next = repeat_count;
            running_next = 1'b1;
          end
          KIND_STOP: begin
            running_next = 1'b0;
            elapsed_next = '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running            <= 1'b0;
      elapsed            <= '0;
      repeats            <= '0;
      alarm_latched      <= 1'b0;
      long_step          <= '0;
      long_timer         <= '0;
      short_beep_enabled <= 1'b1;
      short_step         <= '0;
      short_timer        <= '0;
      beep_timer         <= '0;
      buzzer_level       <= 1'b0;
    end else begin
      running            <= running_next;
      elapsed            <= elapsed_next;
      repeats            <= repeats_next;
      alarm_latched      <= alarm_next;
      long_step          <= long_step_next;
      long_timer         <= long_timer_next;
      short_beep_enabled <= sbe_next;
      short_step         <= short_step_next;
      short_timer        <= short_timer_next;
      beep_timer         <= beep_timer_next;
      buzzer_level       <= buzzer_next;
    end
  end

  // Elapsed is clamped to the duration, so the quotient never exceeds the
  // span and QW quotient bits are enough.
  assign el_clamped = (elapsed > dur_ms) ? dur_ms : elapsed;
  assign div_ge     = (num >= dsh);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      rem_q      <= (dur_ms > elapsed) ? dur_ms - elapsed : '0;
      dur_zero_q <= (dur_ms == '0);
      num        <= NW'(el_clamped) * NW'(PROGRESS_SPAN);
      dsh        <= NW'(dur_ms) << (QW - 1);
      quo        <= '0;
      cnt        <= CW'(QW - 1);
    end else if (cmd.div_step) begin
      if (div_ge) begin
        num <= num - dsh;
      end
      quo <= (quo << 1) | QW'(div_ge);
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign sts.div_last = (cnt == '0);
  assign sts.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      remaining_ms <= rem_q;
      progress     <= dur_zero_q ? '0 : PROG_W'(quo);
      buzzer_on    <= buzzer_level;
      is_running   <= running;
      alarm_active <= alarm_latched;
      runs_left    <= repeats;
    end
  end

  `RCTA_ASSERT_IMPL(a_alarm_stops, clk, rst, alarm_latched, !running)
  `RCTA_ASSERT_IMPL(a_alarm_quiets_short, clk, rst, alarm_latched, !short_beep_enabled)
  `RCTA_ASSERT_NEXT(a_result_shown, clk, rst, cmd.out_load, out_valid)

endmodule

@@ rtl/repeating_countdown_timer_with_alarm.sv @@
// ----------------------------------------------------------------------------
// repeating_countdown_timer_with_alarm
// Top level: millisecond-tick countdown timer with repeats, short beep and
// latched long alarm.
// ----------------------------------------------------------------------------
// Each accepted item (tick, start, stop or no-op) yields exactly one result.
// An item steps through the load, update and result arithmetic states and the
// restoring progress divider, with QW = clog2(PROGRESS_SPAN + 1) quotient
// bits (one quotient bit per cycle, eight at the default span). Its result
// is loaded into the output register once the previous one has been taken,
// and only then is the next item accepted. A finished result waits in the
// output register while the next item is processed. Configuration writes are
// taken at any time but must only be issued while the timer is idle.
// ----------------------------------------------------------------------------
module repeating_countdown_timer_with_alarm import rcta_pkg::*; #(
  parameter int PROGRESS_SPAN  = PROGRESS_SPAN_DEF,
  parameter int BEEP_WINDOW_MS = BEEP_WINDOW_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic                 tap,
  input  logic                 hold,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [EL_W-1:0]      remaining_ms,
  output logic [PROG_W-1:0]    progress,
  output logic                 buzzer_on,
  output logic                 is_running,
  output logic                 alarm_active,
  output logic [REP_W-1:0]     runs_left,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUR_S_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  rcta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rcta_datapath #(
    .PROGRESS_SPAN  (PROGRESS_SPAN),
    .BEEP_WINDOW_MS (BEEP_WINDOW_MS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .tap          (tap),
    .hold         (hold),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .remaining_ms (remaining_ms),
    .progress     (progress),
    .buzzer_on    (buzzer_on),
    .is_running   (is_running),
    .alarm_active (alarm_active),
    .runs_left    (runs_left)
  );

endmodule
